>>> src/plti_pkg.sv
// Package: shared types and constants for the piecewise linear table interpolator.
package plti_pkg;

    localparam int ROWS       = 256;
    localparam int IDX_W      = $clog2(ROWS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DATA_W     = 32;
    localparam int QUEUE_W    = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ABOVE = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // One query handed from front to back.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic [CNT_W-1:0]         rows;
    } t_query;

endpackage

>>> src/plti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/plti_front.sv
// Front end: accepts transactions, performs table writes, queues queries.
module plti_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic [7:0]                   i_row_index,
    input  logic signed [31:0]           i_x_value,
    input  logic signed [31:0]           i_y_value,
    input  logic [8:0]                   i_rows_in_use,
    output logic                         o_we,
    output logic [plti_pkg::IDX_W-1:0]   o_waddr,
    output logic [31:0]                  o_wx,
    output logic [31:0]                  o_wy,
    output logic                         o_q_valid,
    output plti_pkg::t_query             o_q,
    input  logic                         i_q_pop,
    input  logic                         i_back_busy
);
    import plti_pkg::*;

    t_query                r_buf [QUEUE_DEPTH];
    logic [QUEUE_W-1:0]    r_rd;
    logic [QUEUE_W-1:0]    r_wr;
    logic [QUEUE_W:0]      r_cnt;
    logic                  push;
    logic [CNT_W-1:0]      rows_eff;

    // Clamp row count to 2..ROWS
    always_comb begin
        if (i_rows_in_use < 9'd2) begin
            rows_eff = CNT_W'(2);
        end else if (CNT_W'(i_rows_in_use) > CNT_W'(ROWS) || i_rows_in_use > 9'(ROWS)) begin
            rows_eff = CNT_W'(ROWS);
        end else begin
            rows_eff = CNT_W'(i_rows_in_use);
        end
    end

    // Writes wait until no query is pending so order against lookups holds
    always_comb begin
        if (i_op == OP_WRITE) begin
            o_ready = (r_cnt == '0) && !i_back_busy;
        end else begin
            o_ready = (r_cnt != (QUEUE_W+1)'(QUEUE_DEPTH));
        end
    end

    assign push    = i_valid && o_ready && (i_op == OP_QUERY);
    assign o_we    = i_valid && o_ready && (i_op == OP_WRITE) && (32'(i_row_index) < ROWS);
    assign o_waddr = IDX_W'(i_row_index);
    assign o_wx    = i_x_value;
    assign o_wy    = i_y_value;

    // Query queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= '{x: i_x_value, rows: rows_eff};
        end
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (i_q_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QUEUE_W+1)'(push) - (QUEUE_W+1)'(i_q_pop);
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q       = r_buf[r_rd];
endmodule

>>> src/plti_div.sv
// Restoring divider: 64-bit dividend by 33-bit divisor, one quotient bit per cycle.
module plti_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] trial;
    logic [33:0] shifted;

    assign shifted = {r_rem[32:0], r_q[63]};
    assign trial   = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (trial[33]) begin
                    r_rem <= shifted;
                    r_q   <= {r_q[62:0], 1'b0};
                end else begin
                    r_rem <= trial;
                    r_q   <= {r_q[62:0], 1'b1};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> src/plti_back.sv
// Back end: binary search over the table, interpolation and result register.
module plti_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [plti_pkg::IDX_W-1:0]  i_waddr,
    input  logic [31:0]                 i_wx,
    input  logic [31:0]                 i_wy,
    input  logic                        i_q_valid,
    input  plti_pkg::t_query            i_q,
    output logic                        o_q_pop,
    output logic                        o_busy,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [31:0]          o_y_result,
    output logic [1:0]                  o_status,
    output logic [7:0]                  o_segment
);
    import plti_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_LO, S_CHK_LO, S_CHK_HI, S_MID, S_CMP,
        S_RD_PTS, S_PTS1, S_PTS2, S_MUL, S_DIV, S_DONE
    } t_state;

    t_state               r_state;
    logic signed [31:0]   r_x;
    logic [CNT_W-1:0]     r_lo;
    logic [CNT_W-1:0]     r_hi;
    logic [CNT_W-1:0]     r_n;
    logic signed [31:0]   r_x0;
    logic signed [31:0]   r_y0;
    logic [32:0]          r_den;
    logic [32:0]          r_num;
    logic [32:0]          r_mag;
    logic                 r_neg;
    logic [63:0]          r_prod;
    logic                 r_div_go;
    logic                 r_ovalid;
    logic signed [31:0]   r_yres;
    logic [1:0]           r_stat;
    logic [7:0]           r_seg;
    logic [IDX_W-1:0]     raddr;
    logic [31:0]          rx;
    logic [31:0]          ry;
    logic                 div_done;
    logic [63:0]          quot;
    logic signed [33:0]   dy;
    logic signed [34:0]   sum;
    logic [CNT_W-1:0]     mid;

    plti_ram #(.WIDTH(DATA_W), .DEPTH(ROWS)) u_xram (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_waddr), .i_wdata(i_wx),
        .i_raddr(raddr), .o_rdata(rx)
    );
    plti_ram #(.WIDTH(DATA_W), .DEPTH(ROWS)) u_yram (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_waddr), .i_wdata(i_wy),
        .i_raddr(raddr), .o_rdata(ry)
    );

    plti_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_prod), .i_den(r_den), .o_done(div_done), .o_quot(quot)
    );

    assign mid = (r_lo + r_hi) >> 1;

    // Read address by state
    always_comb begin
        case (r_state)
            S_IDLE:   raddr = '0;
            S_RD_LO:  raddr = '0;
            S_CHK_LO: raddr = IDX_W'(r_n - CNT_W'(1));
            S_MID:    raddr = IDX_W'(mid);
            S_RD_PTS: raddr = IDX_W'(r_lo);
            S_PTS1:   raddr = IDX_W'(r_hi);
            default:  raddr = IDX_W'(r_lo);
        endcase
    end

    assign dy  = $signed({{2{ry[31]}}, ry}) - $signed({{2{r_y0[31]}}, r_y0});
    assign sum = r_neg ? ($signed({{3{r_y0[31]}}, r_y0}) - $signed({1'b0, quot[33:0]}))
                       : ($signed({{3{r_y0[31]}}, r_y0}) + $signed({1'b0, quot[33:0]}));

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && !r_ovalid;
    assign o_busy  = (r_state != S_IDLE) || r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_x     <= i_q.x;
                        r_n     <= i_q.rows;
                        r_state <= S_RD_LO;
                    end
                end
                // rx now holds x[0]
                S_RD_LO: r_state <= S_CHK_LO;
                S_CHK_LO: begin
                    if (r_x < $signed(rx)) begin
                        r_yres <= '0; r_stat <= ST_BELOW; r_seg <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CHK_HI;
                    end
                end
                // rx now holds x[n-1]
                S_CHK_HI: begin
                    if (r_x > $signed(rx)) begin
                        r_yres <= '0; r_stat <= ST_ABOVE;
                        r_seg <= 8'(r_n - CNT_W'(2));
                        r_state <= S_DONE;
                    end else begin
                        r_lo <= '0;
                        r_hi <= r_n - CNT_W'(1);
                        r_state <= (r_n == CNT_W'(2)) ? S_RD_PTS : S_MID;
                    end
                end
                S_MID: r_state <= S_CMP;
                S_CMP: begin
                    if ($signed(rx) <= r_x) begin
                        r_lo <= mid;
                        r_state <= (r_hi - mid > CNT_W'(1)) ? S_MID : S_RD_PTS;
                    end else begin
                        r_hi <= mid;
                        r_state <= (mid - r_lo > CNT_W'(1)) ? S_MID : S_RD_PTS;
                    end
                end
                S_RD_PTS: r_state <= S_PTS1;
                // rx/ry hold row lo
                S_PTS1: begin
                    r_x0 <= $signed(rx);
                    r_y0 <= $signed(ry);
                    r_num <= 33'($signed({r_x[31], r_x}) - $signed({rx[31], rx}));
                    r_state <= S_PTS2;
                end
                // rx/ry hold row hi
                S_PTS2: begin
                    r_den <= 33'($signed({rx[31], rx}) - $signed({r_x0[31], r_x0}));
                    r_neg <= dy[33];
                    r_mag <= dy[33] ? 33'(-dy) : 33'(dy);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= 64'(r_mag) * 64'(r_num);
                    if (r_den == '0) begin
                        r_yres <= r_y0; r_stat <= ST_OK; r_seg <= 8'(r_lo);
                        r_state <= S_DONE;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_seg <= 8'(r_lo);
                        if (sum > 35'sd2147483647) begin
                            r_yres <= 32'h7FFF_FFFF; r_stat <= ST_SAT;
                        end else if (sum < -35'sd2147483648) begin
                            r_yres <= 32'h8000_0000; r_stat <= ST_SAT;
                        end else begin
                            r_yres <= 32'(sum); r_stat <= ST_OK;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_ovalid;
    assign o_y_result = r_yres;
    assign o_status   = r_stat;
    assign o_segment  = r_seg;
endmodule

>>> src/piecewise_linear_table_interp_core.sv
// Top level of the piecewise linear table interpolator.
//  channel | direction | handshake              | payload
//  input   | in        | i_valid / o_ready      | op, row_index, x_value, y_value
//  result  | out       | o_valid / i_ready      | y_result, status, segment
//  config  | in        | i_cfg_we               | i_cfg_data (rows_in_use)
// A write goes straight to the table RAMs when accepted. A taken query runs up to 8
// search steps (S_MID, S_CMP) and 64 serial divider steps, then raises o_valid.
// Queries outside the table skip both; zero-width segments skip the divider.
// Up to four queries wait in the queue between front and back.
// Writes are held off while queries are in flight. Reset is synchronous, active low.
module piecewise_linear_table_interp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [7:0]         i_row_index,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_y_result,
    output logic [1:0]         o_status,
    output logic [7:0]         o_segment
);
    import plti_pkg::*;

    logic [8:0]       r_rows;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wx;
    logic [31:0]      wy;
    logic             q_valid;
    t_query           q;
    logic             q_pop;
    logic             back_busy;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 9'd2;
        end else if (i_cfg_we) begin
            r_rows <= i_cfg_data;
        end
    end

    plti_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_row_index(i_row_index), .i_x_value(i_x_value),
        .i_y_value(i_y_value), .i_rows_in_use(r_rows), .o_we(we), .o_waddr(waddr),
        .o_wx(wx), .o_wy(wy), .o_q_valid(q_valid), .o_q(q), .i_q_pop(q_pop),
        .i_back_busy(back_busy)
    );

    plti_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(we), .i_waddr(waddr), .i_wx(wx),
        .i_wy(wy), .i_q_valid(q_valid), .i_q(q), .o_q_pop(q_pop), .o_busy(back_busy),
        .o_valid(o_valid), .i_ready(i_ready), .o_y_result(o_y_result),
        .o_status(o_status), .o_segment(o_segment)
    );
endmodule

>>> src/plti_checker.sv
// Port-level checker for the interpolator core, bound to the top level.
module plti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_y_result,
    input logic [1:0]  o_status,
    input logic [7:0]  o_segment
);
    import plti_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_y_result))
        else $error("result changed while stalled");

    a_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_BELOW |-> o_y_result == '0 && o_segment == '0)
        else $error("below-table result not zero");

    a_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ABOVE |-> o_y_result == '0)
        else $error("above-table result not zero");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind piecewise_linear_table_interp_core plti_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_y_result(o_y_result), .o_status(o_status), .o_segment(o_segment)
);

>>> tb/piecewise_linear_table_interp_core_test.sv
// Self-checking testbench for the piecewise linear table interpolator core.
module piecewise_linear_table_interp_core_test;
    import plti_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int INT_MIN = 32'sh8000_0000;
    localparam int INT_MAX = 2147483647;

    typedef struct {
        logic              op;
        logic [7:0]        row;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_req;

    typedef struct {
        logic signed [31:0] y;
        logic [1:0]         st;
        logic [7:0]         seg;
    } t_interp;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [8:0]         i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_op = OP_WRITE;
    logic [7:0]         i_row_index = '0;
    logic signed [31:0] i_x_value = '0;
    logic signed [31:0] i_y_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_y_result;
    logic [1:0]         o_status;
    logic [7:0]         o_segment;

    // Stimulus and scoreboard state
    t_req    pending_req[$];
    t_interp expected_interp[$];
    logic signed [31:0] bp_x[256];
    logic signed [31:0] bp_y[256];
    logic [8:0] rows_shadow = 9'd2;
    int  gen_x[256];
    bit  failed = 1'b0;
    bit  gaps_on = 1'b1;
    int  idle_cycles = 0;
    int  tx_accepted = 0, tx_seen = 0, tx_gap = 0;
    bit  tx_loaded = 1'b0;
    int  rx_count = 0, rx_seen = 0, rx_gap = 0;
    int  hold_asked = 0, hold_done = 0;

    piecewise_linear_table_interp_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_row_index(i_row_index),
        .i_x_value(i_x_value), .i_y_value(i_y_value),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_y_result(o_y_result), .o_status(o_status), .o_segment(o_segment)
    );

    initial forever #2 i_clk = ~i_clk;

    // Expected interpolation for a query against the shadow table
    function automatic t_interp interpolate(logic signed [31:0] xq);
        t_interp r;
        int n, lo, hi, mid;
        longint x0, x1, y0, y1, dy, acc;
        logic [63:0] num, den, mag, q;
        n = rows_shadow;
        if (n < 2) n = 2;
        if (n > 256) n = 256;
        r.y = '0;
        r.st = ST_OK;
        r.seg = '0;
        if (xq < bp_x[0]) begin
            r.st = ST_BELOW;
            return r;
        end
        if (xq > bp_x[n-1]) begin
            r.st = ST_ABOVE;
            r.seg = 8'(n - 2);
            return r;
        end
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (bp_x[mid] <= xq) lo = mid;
            else hi = mid;
        end
        x0 = bp_x[lo];
        x1 = bp_x[hi];
        y0 = bp_y[lo];
        y1 = bp_y[hi];
        num = longint'(xq) - x0;
        den = x1 - x0;
        dy = y1 - y0;
        mag = (dy < 0) ? -dy : dy;
        q = (den != 0) ? (mag * num) / den : 64'd0;
        acc = (dy < 0) ? y0 - longint'(q) : y0 + longint'(q);
        if (acc > longint'(INT_MAX)) begin
            acc = INT_MAX;
            r.st = ST_SAT;
        end else if (acc < longint'(INT_MIN)) begin
            acc = INT_MIN;
            r.st = ST_SAT;
        end
        r.y = acc[31:0];
        r.seg = 8'(lo);
        return r;
    endfunction

    // Scoreboard: check results, predict on accepted input transactions
    always @(posedge i_clk) begin
        t_interp exp_r;
        if (!i_rst_n) begin
            rows_shadow = 9'd2;
        end else begin
            idle_cycles++;
            if (i_cfg_we) rows_shadow = i_cfg_data;
            if (o_valid && i_ready) begin
                rx_count++;
                idle_cycles = 0;
                if (expected_interp.size() == 0) begin
                    $error("result transaction with no query outstanding");
                    failed = 1'b1;
                end else begin
                    exp_r = expected_interp.pop_front();
                    if (o_y_result !== exp_r.y) begin
                        $error("y_result expected %0d actual %0d", exp_r.y, o_y_result);
                        failed = 1'b1;
                    end
                    if (o_status !== exp_r.st) begin
                        $error("status expected %0d actual %0d", exp_r.st, o_status);
                        failed = 1'b1;
                    end
                    if (o_segment !== exp_r.seg) begin
                        $error("segment expected %0d actual %0d", exp_r.seg, o_segment);
                        failed = 1'b1;
                    end
                end
            end
            if (i_valid && o_ready) begin
                tx_accepted++;
                idle_cycles = 0;
                if (i_op == OP_WRITE) begin
                    bp_x[i_row_index] = i_x_value;
                    bp_y[i_row_index] = i_y_value;
                end else begin
                    expected_interp.push_back(interpolate(i_x_value));
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("piecewise_linear_table_interp_core verification failed");
                $finish;
            end
        end
    end

    // Input driver
    always @(negedge i_clk) begin
        t_req cur;
        if (tx_seen != tx_accepted) begin
            tx_seen = tx_accepted;
            tx_loaded = 1'b0;
            tx_gap = gaps_on ? $urandom_range(0, 12) : 0;
        end
        if (!tx_loaded && i_rst_n) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_req.size() != 0) begin
                cur = pending_req.pop_front();
                tx_loaded = 1'b1;
                i_op <= cur.op;
                i_row_index <= cur.row;
                i_x_value <= cur.x;
                i_y_value <= cur.y;
            end
        end
        i_valid <= tx_loaded;
    end

    // Result receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (rx_seen != rx_count) begin
            rx_seen = rx_count;
            rx_gap = gaps_on ? $urandom_range(0, 12) : 0;
        end
        if (hold_done != hold_asked) begin
            hold_done = hold_asked;
            rx_gap = 600;
        end
        if (rx_gap > 0 && i_rst_n) begin
            rx_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n;
        end
    end

    task automatic put_row(int k, int x, int y);
        t_req r;
        gen_x[k] = x;
        r.op = OP_WRITE;
        r.row = 8'(k);
        r.x = x;
        r.y = y;
        pending_req.push_back(r);
    endtask

    task automatic query(int x);
        t_req r;
        r.op = OP_QUERY;
        r.row = 8'($urandom);
        r.x = x;
        r.y = $urandom;
        pending_req.push_back(r);
    endtask

    function automatic int rand_between(longint a, longint b);
        longint t;
        logic [63:0] r;
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
        r = {$urandom, $urandom};
        return int'(a + longint'(r % (b - a + 1)));
    endfunction

    // Wait until the block has drained, then let in-flight work finish
    task automatic settle();
        while (pending_req.size() != 0 || i_valid || expected_interp.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic set_rows(logic [8:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        int cfg_list[10] = '{3, 0, 17, 256, 511, 1, 5, 64, 2, 9};
        int vals[$];
        int n, kind, k, sel;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: full-range extremes on two rows
        put_row(0, INT_MIN, INT_MAX);
        put_row(1, INT_MAX, INT_MIN);
        query(INT_MIN); query(INT_MAX); query(0); query(-1); query(1);
        query(32'h4000_0000);
        // Small table: below, above, edges, interior truncation
        put_row(0, -65536, 5);
        put_row(1, 65536, -7);
        query(INT_MIN); query(INT_MAX); query(-65536); query(65536);
        query(-65537); query(65537); query(0); query(12345);
        // Zero-width segment returns y0
        put_row(1, -65536, 100);
        query(-65536); query(-65535); query(-65537);
        put_row(255, 1, -1);
        settle();

        for (int ph = 0; ph < 10; ph++) begin
            gaps_on = (ph % 4 != 1);
            set_rows(9'(cfg_list[ph]));
            n = cfg_list[ph];
            if (n < 2) n = 2;
            if (n > 256) n = 256;
            kind = (ph == 6 || ph == 1) ? 1 : (ph == 9 ? 2 : 0);
            // reuse the full table already loaded in the previous phase
            if (cfg_list[ph] != 511) begin
                vals.delete();
                for (k = 0; k < n; k++) begin
                    if (kind == 1) vals.push_back(($urandom_range(0, 6) - 3) * 65536);
                    else vals.push_back(int'($urandom));
                end
                if (kind != 2) vals.sort();
                for (k = 0; k < n; k++) put_row(k, vals[k], $urandom);
            end
            // long receiver hold-off once the table is loaded, so queries back up
            if (ph == 3) begin
                settle();
                hold_asked++;
            end
            for (int j = 0; j < 30; j++) begin
                sel = $urandom_range(0, 9);
                case (sel)
                    0, 1, 2, 3: query(rand_between(gen_x[0], gen_x[n-1]));
                    4, 5: query(gen_x[$urandom_range(0, n - 1)]);
                    6: query(gen_x[0] > INT_MIN ? rand_between(INT_MIN, gen_x[0] - 1) : INT_MIN);
                    7: query(gen_x[n-1] < INT_MAX ? rand_between(gen_x[n-1] + 1, INT_MAX)
                                                 : INT_MAX);
                    8: query($urandom);
                    default: begin
                        k = $urandom_range(0, n - 1);
                        put_row(k, kind == 2 ? int'($urandom) : gen_x[k], $urandom);
                    end
                endcase
            end
            settle();
        end

        if (!failed)
            $display("piecewise_linear_table_interp_core verification clean");
        else
            $display("piecewise_linear_table_interp_core verification failed");
        $finish;
    end

endmodule

>>> piecewise_linear_table_interp_core.f
src/plti_pkg.sv
src/plti_ram.sv
src/plti_front.sv
src/plti_div.sv
src/plti_back.sv
src/piecewise_linear_table_interp_core.sv
src/plti_checker.sv
tb/piecewise_linear_table_interp_core_test.sv
